// ===== src/rrs_pkg.sv =====
`default_nettype none

package rrs_pkg;

   localparam int SAMPLE_W       = 32;
   localparam int CNT_W          = 7;
   localparam int OUT_W          = 48;
   localparam int CSR_DATA_W     = 48;
   localparam int CSR_IDX_W      = 2;
   localparam int REQ_USER_W     = 1;
   localparam int RSP_USER_W     = 2;
   localparam int MIN_WINDOW     = 2;
   localparam int DEF_MAX_WINDOW = 64;

   localparam logic signed [OUT_W-1:0] SLOPE_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] SLOPE_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LENGTH  = 2'd0,
      CSR_PARTIAL_ENABLE = 2'd1,
      CSR_LEAST_COUNT    = 2'd2,
      CSR_FILL_VALUE     = 2'd3
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DROP_SUM,
      ST_DROP_WSUM,
      ST_MUL_NEW,
      ST_APPEND,
      ST_CHECK,
      ST_MUL_TREND,
      ST_DIFF,
      ST_SCALE,
      ST_MAG,
      ST_MUL_NSQ,
      ST_MUL_NCUBE,
      ST_DEN,
      ST_DIV,
      ST_SLOPE_OUT,
      ST_FILL_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_DROP_SUM,
      OP_DROP_WSUM,
      OP_MUL_NEW,
      OP_APPEND,
      OP_MUL_TREND,
      OP_DIFF,
      OP_SCALE,
      OP_MAG,
      OP_MUL_NSQ,
      OP_MUL_NCUBE,
      OP_DEN,
      OP_DIV_STEP,
      OP_LOAD_SLOPE,
      OP_LOAD_FILL
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic need_drop;
      logic compute;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== src/rolling_regression_slope.sv =====
// Channel   Ports        Transaction contents
// req       req_t*       sample (tdata), series_start (tuser)
// rsp       rsp_t*       slope (tdata), slope_valid and saturated (tuser)
// csr       csr_*        one register write per cycle with csr_wr_en high
//
// An item whose slope is computed drops the oldest sample when the window is full, then
// runs its multiply steps on the single shared multiplier and a restoring divide of one
// quotient bit per step, one per numerator bit (49 at the default window); a fill result
// skips the divide. Reset sets the window length to its minimum and clears the other CSRs,
// the running sums, sample count, write pointer and result valid flag.
// A finished result waits in the output register while the next item is taken,
// and a stalled rsp channel holds the next result until the register frees.
`default_nettype none

module rolling_regression_slope #(
   parameter int MAX_WINDOW = rrs_pkg::DEF_MAX_WINDOW
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [rrs_pkg::SAMPLE_W-1:0]        req_tdata,   // sample
   input  wire  [rrs_pkg::REQ_USER_W-1:0]      req_tuser,   // series_start
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [rrs_pkg::OUT_W-1:0]           rsp_tdata,   // slope
   output logic [rrs_pkg::RSP_USER_W-1:0]      rsp_tuser,   // slope_valid, saturated
   input  wire                                 csr_wr_en,
   input  wire  [rrs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [rrs_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rrs_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rrs_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

`default_nettype wire

// ===== src/rrs_ctrl.sv =====
`default_nettype none

module rrs_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  rrs_pkg::dp_status_type status,
   output rrs_pkg::dp_cmd_type    cmd
);
   import rrs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_ACCEPT;
               state_in = ST_DROP_SUM;
            end
         end
         ST_DROP_SUM: begin
            if (status.need_drop) begin
               cmd.op   = OP_DROP_SUM;
               state_in = ST_DROP_WSUM;
            end else begin
               state_in = ST_MUL_NEW;
            end
         end
         ST_DROP_WSUM: begin
            cmd.op   = OP_DROP_WSUM;
            state_in = ST_MUL_NEW;
         end
         ST_MUL_NEW: begin
            cmd.op   = OP_MUL_NEW;
            state_in = ST_APPEND;
         end
         ST_APPEND: begin
            cmd.op   = OP_APPEND;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.compute ? ST_MUL_TREND : ST_FILL_OUT;
         end
         ST_MUL_TREND: begin
            cmd.op   = OP_MUL_TREND;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            cmd.op   = OP_MAG;
            state_in = ST_MUL_NSQ;
         end
         ST_MUL_NSQ: begin
            cmd.op   = OP_MUL_NSQ;
            state_in = ST_MUL_NCUBE;
         end
         ST_MUL_NCUBE: begin
            cmd.op   = OP_MUL_NCUBE;
            state_in = ST_DEN;
         end
         ST_DEN: begin
            cmd.op   = OP_DEN;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (status.div_last) begin
               state_in = ST_SLOPE_OUT;
            end
         end
         ST_SLOPE_OUT: begin
            if (status.out_free) begin
               cmd.op   = OP_LOAD_SLOPE;
               state_in = ST_IDLE;
            end
         end
         ST_FILL_OUT: begin
            if (status.out_free) begin
               cmd.op   = OP_LOAD_FILL;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/rrs_datapath.sv =====
`default_nettype none

module rrs_datapath #(
   parameter int MAX_WINDOW = rrs_pkg::DEF_MAX_WINDOW
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  rrs_pkg::dp_cmd_type                     cmd,
   output rrs_pkg::dp_status_type                  status,
   input  wire  [rrs_pkg::SAMPLE_W-1:0]            req_tdata,
   input  wire  [rrs_pkg::REQ_USER_W-1:0]          req_tuser,
   output logic                                    rsp_tvalid,
   input  wire                                     rsp_tready,
   output logic [rrs_pkg::OUT_W-1:0]               rsp_tdata,
   output logic [rrs_pkg::RSP_USER_W-1:0]          rsp_tuser,
   input  wire                                     csr_wr_en,
   input  wire  [rrs_pkg::CSR_IDX_W-1:0]           csr_index,
   input  wire  [rrs_pkg::CSR_DATA_W-1:0]          csr_wdata
);
   import rrs_pkg::*;

   localparam int LOG_W  = $clog2(MAX_WINDOW);
   localparam int PTR_W  = LOG_W;
   localparam int SUM_W  = SAMPLE_W + LOG_W;
   localparam int WSUM_W = SAMPLE_W + 2 * LOG_W;
   localparam int MUL_W  = SUM_W + CNT_W + 1;
   localparam int DIFF_W = WSUM_W + 2;
   localparam int NUM_W  = DIFF_W + 3;
   localparam int DEN_W  = 3 * CNT_W;
   localparam int DIVC_W = $clog2(NUM_W);
   localparam int CMP_W  = (NUM_W + 1 > OUT_W) ? NUM_W + 1 : OUT_W;
   localparam int AW     = ((LOG_W > CNT_W) ? LOG_W : CNT_W) + 1;

   logic signed [SAMPLE_W-1:0] hist [MAX_WINDOW];

   logic [CNT_W-1:0]           wl_ff, wl_in;
   logic                       part_ff, part_in;
   logic [CNT_W-1:0]           least_ff, least_in;
   logic [OUT_W-1:0]           fill_ff, fill_in;

   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] old_ff;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [WSUM_W-1:0]   wsum_ff, wsum_in;
   logic [CNT_W-1:0]           seen_ff, seen_in;
   logic [PTR_W-1:0]           wp_ff, wp_in;
   logic signed [MUL_W-1:0]    mul_ff, mul_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic                       neg_ff, neg_in;
   logic [NUM_W-1:0]           quo_ff, quo_in;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic [DIVC_W-1:0]          cnt_ff, cnt_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]           rsp_slope_ff, rsp_slope_in;
   logic                       rsp_sv_ff, rsp_sv_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   logic signed [SUM_W-1:0]    mul_a;
   logic [CNT_W-1:0]           mul_b;
   logic [AW-1:0]              wp_ext;
   logic [AW-1:0]              wl_ext;
   logic [AW-1:0]              old_idx_wide;
   logic [PTR_W-1:0]           old_idx;
   logic [CNT_W-1:0]           wl_req;
   logic signed [NUM_W-1:0]    num_scaled;
   logic [DEN_W:0]             div_shift;
   logic [DEN_W:0]             div_trial;
   logic signed [CMP_W-1:0]    q_ext;
   logic signed [CMP_W-1:0]    q_val;

   always_comb begin
      wp_ext       = AW'(wp_ff);
      wl_ext       = AW'(wl_ff);
      old_idx_wide = (wp_ext >= wl_ext) ? wp_ext - wl_ext
                                        : wp_ext + AW'(MAX_WINDOW) - wl_ext;
      old_idx      = old_idx_wide[PTR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_APPEND) begin
         hist[wp_ff] <= x_ff;
      end
      if (cmd.op == OP_ACCEPT) begin
         old_ff <= hist[old_idx];
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_NEW: begin
            mul_a = SUM_W'(x_ff);
            mul_b = seen_ff;
         end
         OP_MUL_TREND: begin
            mul_a = sum_ff;
            mul_b = seen_ff - CNT_W'(1);
         end
         OP_MUL_NSQ: begin
            mul_a = SUM_W'(seen_ff);
            mul_b = seen_ff;
         end
         OP_MUL_NCUBE: begin
            mul_a = SUM_W'(mul_ff);
            mul_b = seen_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      wl_in        = wl_ff;
      part_in      = part_ff;
      least_in     = least_ff;
      fill_in      = fill_ff;
      x_in         = x_ff;
      sum_in       = sum_ff;
      wsum_in      = wsum_ff;
      seen_in      = seen_ff;
      wp_in        = wp_ff;
      mul_in       = mul_ff;
      diff_in      = diff_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_slope_in = rsp_slope_ff;
      rsp_sv_in    = rsp_sv_ff;
      rsp_sat_in   = rsp_sat_ff;
      wl_req       = csr_wdata[CNT_W-1:0];
      num_scaled   = (NUM_W'(diff_ff) <<< 2) + (NUM_W'(diff_ff) <<< 1);
      div_shift    = {rem_ff, quo_ff[NUM_W-1]};
      div_trial    = div_shift - {1'b0, den_ff};
      q_ext        = CMP_W'($signed({1'b0, quo_ff}));
      q_val        = neg_ff ? -q_ext : q_ext;

      case (cmd.op)
         OP_ACCEPT: begin
            x_in = $signed(req_tdata);
            if (req_tuser[0]) begin
               sum_in  = '0;
               wsum_in = '0;
               seen_in = '0;
            end
         end
         OP_DROP_SUM: begin
            sum_in  = sum_ff - SUM_W'(old_ff);
            seen_in = wl_ff - CNT_W'(1);
         end
         OP_DROP_WSUM: begin
            wsum_in = wsum_ff - WSUM_W'(sum_ff);
         end
         OP_MUL_NEW, OP_MUL_TREND, OP_MUL_NSQ, OP_MUL_NCUBE: begin
            mul_in = mul_a * $signed({1'b0, mul_b});
         end
         OP_APPEND: begin
            wsum_in = wsum_ff + WSUM_W'(mul_ff);
            sum_in  = sum_ff + SUM_W'(x_ff);
            seen_in = seen_ff + CNT_W'(1);
            wp_in   = (wp_ff == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_ff + PTR_W'(1);
         end
         OP_DIFF: begin
            diff_in = (DIFF_W'(wsum_ff) <<< 1) - DIFF_W'(mul_ff);
         end
         OP_SCALE: begin
            quo_in = num_scaled;
            neg_in = diff_ff[DIFF_W-1];
         end
         OP_MAG: begin
            if (neg_ff) begin
               quo_in = -quo_ff;
            end
            rem_in = '0;
            cnt_in = '0;
         end
         OP_DEN: begin
            den_in = DEN_W'(mul_ff) - DEN_W'(seen_ff);
         end
         OP_DIV_STEP: begin
            if (!div_trial[DEN_W]) begin
               rem_in = div_trial[DEN_W-1:0];
               quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = div_shift[DEN_W-1:0];
               quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + DIVC_W'(1);
         end
         OP_LOAD_SLOPE: begin
            rsp_valid_in = 1'b1;
            rsp_sv_in    = 1'b1;
            if (q_val > CMP_W'(SLOPE_MAX)) begin
               rsp_slope_in = SLOPE_MAX;
               rsp_sat_in   = 1'b1;
            end else if (q_val < CMP_W'(SLOPE_MIN)) begin
               rsp_slope_in = SLOPE_MIN;
               rsp_sat_in   = 1'b1;
            end else begin
               rsp_slope_in = q_val[OUT_W-1:0];
               rsp_sat_in   = 1'b0;
            end
         end
         OP_LOAD_FILL: begin
            rsp_valid_in = 1'b1;
            rsp_slope_in = fill_ff;
            rsp_sv_in    = 1'b0;
            rsp_sat_in   = 1'b0;
         end
         default: begin
            x_in = x_ff;
         end
      endcase

      if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            CSR_WINDOW_LENGTH: begin
               if (wl_req < CNT_W'(MIN_WINDOW)) begin
                  wl_in = CNT_W'(MIN_WINDOW);
               end else if (int'(wl_req) > MAX_WINDOW) begin
                  wl_in = CNT_W'(MAX_WINDOW);
               end else begin
                  wl_in = wl_req;
               end
               sum_in  = '0;
               wsum_in = '0;
               seen_in = '0;
            end
            CSR_PARTIAL_ENABLE: begin
               part_in = csr_wdata[0];
            end
            CSR_LEAST_COUNT: begin
               least_in = csr_wdata[CNT_W-1:0];
            end
            CSR_FILL_VALUE: begin
               fill_in = csr_wdata[OUT_W-1:0];
            end
            default: begin
               part_in = part_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff        <= CNT_W'(MIN_WINDOW);
         part_ff      <= 1'b0;
         least_ff     <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         wsum_ff      <= '0;
         seen_ff      <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wl_ff        <= wl_in;
         part_ff      <= part_in;
         least_ff     <= least_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         wsum_ff      <= wsum_in;
         seen_ff      <= seen_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      mul_ff       <= mul_in;
      diff_ff      <= diff_in;
      neg_ff       <= neg_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      cnt_ff       <= cnt_in;
      rsp_slope_ff <= rsp_slope_in;
      rsp_sv_ff    <= rsp_sv_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   always_comb begin
      status.need_drop = (seen_ff >= wl_ff);
      status.compute   = ((seen_ff >= wl_ff) || (part_ff && (seen_ff >= least_ff)))
                         && (seen_ff >= CNT_W'(MIN_WINDOW));
      status.div_last  = (cnt_ff == DIVC_W'(NUM_W - 1));
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_slope_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_sv_ff};

endmodule

`default_nettype wire

// ===== src/rrs_checker.sv =====
`default_nettype none

module rrs_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_tvalid,
   input wire                            req_tready,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [rrs_pkg::OUT_W-1:0]       rsp_tdata,
   input wire [rrs_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import rrs_pkg::*;

   // A result that is not taken stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // The block does not take a sample in the cycle after it takes one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted on consecutive cycles");

   // A fill result is never flagged as clipped.
   a_sat_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("saturated flag set on a fill result");

   // A clipped slope sits at one end of the output range.
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         (rsp_tdata == SLOPE_MAX) || (rsp_tdata == SLOPE_MIN))
      else $error("saturated slope not at range limit");

   // Reset empties the result register.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind rolling_regression_slope rrs_checker u_rrs_checker (.*);

`default_nettype wire
